// ----- rtl/source_token_scanner_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the source token scanner
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_SCANNER_UNIT_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The condition holds at every clock edge outside reset.
`define STSC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scanner check failed");
// When pre holds, post holds at the next clock edge.
`define STSC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scanner sequence check failed");
`else
`define STSC_ASSERT(lbl, cond)
`define STSC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- rtl/stsc_pkg.sv -----
// ----------------------------------------------------------------------------
// stsc_pkg
// Types, constants, keyword and phrase tables shared by the scanner modules.
// ----------------------------------------------------------------------------
package stsc_pkg;

  localparam int LINE_BITS       = 20;
  localparam int COLUMN_BITS     = 16;
  localparam int LENGTH_BITS     = 12;
  localparam int LOOKAHEAD_DEPTH = 14;
  localparam int PREFIX_DEPTH    = 11;
  localparam int KIND_BITS       = 6;
  localparam int CODE_BITS       = 8;
  localparam int LA_IDX_BITS     = $clog2(LOOKAHEAD_DEPTH);
  localparam int LA_CNT_BITS     = $clog2(LOOKAHEAD_DEPTH + 1);
  localparam int PFX_IDX_BITS    = $clog2(PREFIX_DEPTH);
  localparam int Q_DEPTH         = 4;
  localparam int Q_PTR_BITS      = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS      = $clog2(Q_DEPTH + 1);
  localparam int KW_COUNT        = 29;
  localparam int KW_MAX_LEN      = 9;

  // Token kinds. Punctuation kinds equal the punctuation index.
  localparam logic [KIND_BITS-1:0] KIND_STRING   = 6'd9;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 6'd10;
  localparam logic [KIND_BITS-1:0] KIND_ARROW    = 6'd11;
  localparam logic [KIND_BITS-1:0] KIND_PIPE     = 6'd12;
  localparam logic [KIND_BITS-1:0] KIND_COMPARE  = 6'd13;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_OPER     = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_TAKDIR   = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_PRAGMA   = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd36;
  localparam logic [KIND_BITS-1:0] KIND_MISMATCH = 6'd37;
  localparam logic [KIND_BITS-1:0] KIND_EOF      = 6'd38;

  localparam logic [7:0] CH_SPACE   = " ";
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CARET   = "^";
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = "'";
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DOT     = ".";
  localparam logic [7:0] CH_EQ      = "=";
  localparam logic [7:0] CH_BANG    = "!";
  localparam logic [7:0] CH_GT      = ">";
  localparam logic [7:0] CH_LT      = "<";
  localparam logic [7:0] CH_BAR     = "|";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_PERCENT = "%";
  localparam logic [7:0] CH_UNDER   = "_";
  localparam logic [7:0] CH_LOW_S   = "s";
  localparam logic [7:0] CH_LOW_H   = "h";
  localparam logic [7:0] CH_LOW_B   = "b";

  localparam logic [8*9-1:0] PUNCT_CHARS = "(){}[],:.";

  typedef struct packed {
    logic       is_end;
    logic [7:0] ch;
    logic       digit;
    logic       alpha;
    logic       ident;
  } sym_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [LENGTH_BITS-1:0] length;
    logic [CODE_BITS-1:0]   code;
  } rec_t;

  typedef struct packed {
    logic                 hit;
    logic [KIND_BITS-1:0] kind;
    logic [2:0]           code;
  } kw_t;

  function automatic sym_t classify(input logic is_end, input logic [7:0] ch);
    sym_t s;
    s.is_end = is_end;
    s.ch     = ch;
    s.digit  = (ch >= "0") && (ch <= "9");
    s.alpha  = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    s.ident  = s.digit || s.alpha || (ch == CH_UNDER);
    return s;
  endfunction

  // Keyword texts are right aligned; lengths, kinds and codes follow.
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    72'("datang"), 72'("cocokkan"), 72'("kasus"), 72'("jika"), 72'("kecuali"),
    72'("maka"), 72'("lain"), 72'("putus"), 72'("effort"), 72'("kali"),
    72'("dan"), 72'("atau"), 72'("bukan"), 72'("coba"), 72'("tabu"),
    72'("melanggar"), 72'("tebus"), 72'("pasrah"), 72'("ciptakan"),
    72'("fungsi"), 72'("pulang"), 72'("sowan"), 72'("utas"), 72'("gaib"),
    72'("pergi"), 72'("henti"), 72'("balikan"), 72'("terus"), 72'("jadwal")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd8, 4'd5, 4'd4, 4'd7, 4'd4, 4'd4, 4'd5, 4'd6, 4'd4,
    4'd3, 4'd4, 4'd5, 4'd4, 4'd4, 4'd9, 4'd5, 4'd6, 4'd8, 4'd6,
    4'd6, 4'd5, 4'd4, 4'd4, 4'd5, 4'd5, 4'd7, 4'd5, 4'd6
  };
  localparam logic [KIND_BITS-1:0] KW_KIND [KW_COUNT] = '{
    6'd18, 6'd19, 6'd20, 6'd21, 6'd21, 6'd21, 6'd21, 6'd21, 6'd22, 6'd22,
    6'd23, 6'd23, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
    6'd31, 6'd32, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34, 6'd34, 6'd35
  };
  localparam logic [2:0] KW_CODE [KW_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1,
    3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0
  };

  // The word holds its first bytes left aligned, byte 0 in the top byte.
  function automatic kw_t kw_lookup(input logic [8*KW_MAX_LEN-1:0] word,
                                    input logic [LENGTH_BITS-1:0] len);
    kw_t                       r;
    logic [8*KW_MAX_LEN-1:0] ent;
    logic [8*KW_MAX_LEN-1:0] mask;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      ent  = KW_TEXT[i] << (8 * (KW_MAX_LEN - int'(KW_LEN[i])));
      mask = ~({(8*KW_MAX_LEN){1'b1}} >> (8 * int'(KW_LEN[i])));
      if ((len == LENGTH_BITS'(KW_LEN[i])) && ((word & mask) == ent)) begin
        r.hit  = 1'b1;
        r.kind = KW_KIND[i];
        r.code = KW_CODE[i];
      end
    end
    return r;
  endfunction

  localparam int PHR_BITS = 8 * LOOKAHEAD_DEPTH;
  localparam logic [111:0] PHRASE_TEXT [3] = '{
    {" .anu", 72'h0}, " array.dinamis", {" array.statis", 8'h0}
  };
  localparam logic [3:0] PHRASE_LEN [3] = '{4'd5, 4'd14, 4'd13};

  function automatic logic [7:0] phrase_byte(input logic [1:0] k,
                                             input logic [LA_CNT_BITS-1:0] n);
    logic [111:0] t;
    t = PHRASE_TEXT[k];
    return t[111 - 8*int'(n) -: 8];
  endfunction

  localparam logic [31:0] TAKDIR_SOFT = "soft";
  localparam logic [31:0] TAKDIR_HARD = "hard";

  function automatic logic [7:0] takdir_byte(input logic hard,
                                             input logic [LA_CNT_BITS-1:0] n);
    logic [31:0] t;
    t = hard ? TAKDIR_HARD : TAKDIR_SOFT;
    return t[31 - 8*(int'(n) - 1) -: 8];
  endfunction

endpackage

// ----- rtl/source_token_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// source_token_scanner_unit
// Streaming lexer: source bytes in, token records out.
// ----------------------------------------------------------------------------
// Flow: accepted bytes wait in the front queue; the core loads one symbol at a
// time and runs lexer steps on it until it is consumed, and each record passes
// the hold register and then the output register. The final record flush
// overlaps the next load, and a failed lookahead phrase replays up to fourteen
// buffered bytes, one step each.
// Reset: rst_n is synchronous and active low; it clears the queue, counters,
// lexing mode and output stage at once, with no clearing pass.
`include "source_token_scanner_unit_macros.svh"

module source_token_scanner_unit import stsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_ch,
  input  logic                   in_at_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_BITS-1:0]   out_kind,
  output logic [LINE_BITS-1:0]   out_line,
  output logic [COLUMN_BITS-1:0] out_column,
  output logic [LENGTH_BITS-1:0] out_length,
  output logic [CODE_BITS-1:0]   out_word_code,
  output logic                   out_last
);

  logic sym_valid;
  sym_t sym;
  logic sym_pop;

  stsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_ch),
    .in_at_end (in_at_end),
    .sym_valid (sym_valid),
    .sym_out   (sym),
    .sym_pop   (sym_pop)
  );

  stsc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .sym_valid     (sym_valid),
    .sym_in        (sym),
    .sym_pop       (sym_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_line      (out_line),
    .out_column    (out_column),
    .out_length    (out_length),
    .out_word_code (out_word_code),
    .out_last      (out_last)
  );

  `STSC_ASSERT(a_ready_while_queue_free, !(in_valid && !in_ready) || sym_valid)
  `STSC_ASSERT(a_record_valid_kind, !out_valid || out_kind <= KIND_EOF)
  `STSC_ASSERT(a_eof_is_last, !(out_valid && out_kind == KIND_EOF) || out_last)

endmodule

// ----- rtl/stsc_front.sv -----
// ----------------------------------------------------------------------------
// stsc_front
// Accepts source bytes, classifies them and queues them for the lexer core.
// ----------------------------------------------------------------------------
module stsc_front import stsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_at_end,
  output logic       sym_valid,
  output sym_t       sym_out,
  input  logic       sym_pop
);

  sym_t                  q_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_r, wr_nxt;
  logic [Q_PTR_BITS-1:0] rd_r, rd_nxt;
  logic [Q_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  push;
  logic                  pop;

  assign in_ready  = (cnt_r != Q_CNT_BITS'(Q_DEPTH));
  assign sym_valid = (cnt_r != '0);
  assign sym_out   = q_r[rd_r];
  assign push      = in_valid && in_ready;
  assign pop       = sym_pop && sym_valid;

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= classify(in_at_end, in_ch);
    end
  end

endmodule

// ----- rtl/stsc_back.sv -----
// ----------------------------------------------------------------------------
// stsc_back
// Lexer core: one step per cycle unless stalled; lookahead replay; records.
// ----------------------------------------------------------------------------
`include "source_token_scanner_unit_macros.svh"

module stsc_back import stsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   sym_valid,
  input  sym_t                   sym_in,
  output logic                   sym_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_BITS-1:0]   out_kind,
  output logic [LINE_BITS-1:0]   out_line,
  output logic [COLUMN_BITS-1:0] out_column,
  output logic [LENGTH_BITS-1:0] out_length,
  output logic [CODE_BITS-1:0]   out_word_code,
  output logic                   out_last
);

  typedef enum logic [3:0] {
    M_IDLE, M_CARET, M_COMMENT, M_STRING, M_ESCAPE, M_NUMBER,
    M_OPER, M_WORD, M_WORD_PLAIN, M_TAKDIR, M_PRAGMA
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic                   have_r, have_nxt;
  sym_t                   sym_r, sym_nxt;
  logic [LA_CNT_BITS-1:0] rep_cnt_r, rep_cnt_nxt;
  logic [LA_CNT_BITS-1:0] rep_idx_r, rep_idx_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [COLUMN_BITS-1:0] tsc_r, tsc_nxt;
  logic [LENGTH_BITS-1:0] tlen_r, tlen_nxt;
  logic                   qs_r, qs_nxt;
  logic [7:0]             pop_r, pop_nxt;
  logic [LA_CNT_BITS-1:0] lacnt_r, lacnt_nxt;
  logic [2:0]             alive_r, alive_nxt;
  logic                   hold_v_r, hold_v_nxt;
  logic                   hold_last_r, hold_last_nxt;
  rec_t                   hold_r, hold_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rec_t                   out_rec_r, out_rec_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [7:0]             wp_r [PREFIX_DEPTH];
  logic [7:0]             la_r [LOOKAHEAD_DEPTH];

  logic                   replaying;
  sym_t                   cur;
  logic                   out_free;
  logic                   step;
  logic                   finish;
  logic                   emit;
  rec_t                   erec;
  logic                   consume;
  logic                   rep_go;
  logic                   wp_we;
  logic [PFX_IDX_BITS-1:0] wp_idx;
  logic                   la_we;
  logic [LA_IDX_BITS-1:0] la_idx;
  logic [7:0]             wr_byte;
  logic [8*KW_MAX_LEN-1:0] word;
  kw_t                    kw;

  function automatic logic [COLUMN_BITS-1:0] col_plus(input logic [COLUMN_BITS-1:0] base,
                                                      input logic [4:0] n);
    logic [COLUMN_BITS:0] sum;
    sum = {1'b0, base} + (COLUMN_BITS+1)'(n);
    return sum[COLUMN_BITS] ? {COLUMN_BITS{1'b1}} : sum[COLUMN_BITS-1:0];
  endfunction

  assign replaying = (rep_idx_r != rep_cnt_r);
  assign cur       = replaying ? classify(1'b0, la_r[rep_idx_r[LA_IDX_BITS-1:0]]) : sym_r;
  assign out_free  = !out_valid_r || out_ready;
  assign step      = have_r && !hold_last_r && (!hold_v_r || out_free);
  assign finish    = step && consume && !replaying;
  assign sym_pop   = !have_r && sym_valid;

  always_comb begin
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      word[8*KW_MAX_LEN-1 - 8*i -: 8] = wp_r[i];
    end
    kw = kw_lookup(word, tlen_r);
  end

  // One lexer step on the current symbol.
  always_comb begin
    logic [7:0] c;
    logic       s_end;
    logic       fail;
    logic       done;
    logic [1:0] done_k;
    logic [2:0] new_alive;
    logic       is_punct;
    logic [3:0] punct_k;
    c         = cur.ch;
    s_end     = cur.is_end;
    fail      = 1'b0;
    done      = 1'b0;
    done_k    = '0;
    new_alive = '0;
    is_punct  = 1'b0;
    punct_k   = '0;
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tsc_nxt   = tsc_r;
    tlen_nxt  = tlen_r;
    qs_nxt    = qs_r;
    pop_nxt   = pop_r;
    lacnt_nxt = lacnt_r;
    alive_nxt = alive_r;
    emit      = 1'b0;
    erec      = '0;
    erec.line = line_r;
    consume   = 1'b1;
    rep_go    = 1'b0;
    wp_we     = 1'b0;
    wp_idx    = tlen_r[PFX_IDX_BITS-1:0];
    la_we     = 1'b0;
    la_idx    = lacnt_r[LA_IDX_BITS-1:0];
    wr_byte   = c;
    for (int k = 0; k < 9; k++) begin
      if (PUNCT_CHARS[8*(8-k) +: 8] == c) begin
        is_punct = 1'b1;
        punct_k  = 4'(k);
      end
    end
    case (mode_r)
      M_IDLE: begin
        if (s_end) begin
          emit        = 1'b1;
          erec.kind   = KIND_EOF;
          erec.column = col_r;
          line_nxt    = LINE_BITS'(1);
          col_nxt     = COLUMN_BITS'(1);
          tsc_nxt     = '0;
          tlen_nxt    = '0;
          qs_nxt      = 1'b0;
          pop_nxt     = '0;
          lacnt_nxt   = '0;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
          col_nxt = col_plus(col_r, 5'd1);
        end else if (c == CH_NL) begin
          if (line_r != {LINE_BITS{1'b1}}) line_nxt = line_r + 1'b1;
          col_nxt = COLUMN_BITS'(1);
        end else if (c == CH_CARET) begin
          mode_nxt = M_CARET;
          tsc_nxt  = col_r;
        end else if (is_punct) begin
          emit        = 1'b1;
          erec.kind   = KIND_BITS'(punct_k);
          erec.column = col_r;
          erec.length = LENGTH_BITS'(1);
          erec.code   = c;
          col_nxt     = col_plus(col_r, 5'd1);
        end else begin
          tsc_nxt = col_r;
          if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            mode_nxt = M_STRING;
            qs_nxt   = (c == CH_SQUOTE);
            tlen_nxt = LENGTH_BITS'(1);
            col_nxt  = col_plus(col_r, 5'd1);
          end else if (cur.digit) begin
            mode_nxt = M_NUMBER;
            tlen_nxt = LENGTH_BITS'(1);
            col_nxt  = col_plus(col_r, 5'd1);
          end else if (c == CH_EQ || c == CH_BANG || c == CH_GT || c == CH_LT ||
                       c == CH_BAR) begin
            mode_nxt = M_OPER;
            pop_nxt  = c;
          end else if (cur.alpha || c == CH_UNDER) begin
            mode_nxt = M_WORD;
            wp_we    = 1'b1;
            wp_idx   = '0;
            tlen_nxt = LENGTH_BITS'(1);
            col_nxt  = col_plus(col_r, 5'd1);
          end else begin
            emit        = 1'b1;
            erec.kind   = (c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
                           c == CH_SLASH || c == CH_PERCENT) ? KIND_OPER : KIND_MISMATCH;
            erec.column = col_r;
            erec.length = LENGTH_BITS'(1);
            erec.code   = c;
            col_nxt     = col_plus(col_r, 5'd1);
          end
        end
      end
      M_CARET: begin
        if (!s_end && c == CH_CARET) begin
          mode_nxt = M_COMMENT;
        end else begin
          emit        = 1'b1;
          erec.kind   = KIND_OPER;
          erec.column = tsc_r;
          erec.length = LENGTH_BITS'(1);
          erec.code   = CH_CARET;
          col_nxt     = col_plus(col_r, 5'd1);
          mode_nxt    = M_IDLE;
          consume     = 1'b0;
        end
      end
      M_COMMENT: begin
        if (s_end || c == CH_NL) begin
          mode_nxt = M_IDLE;
          consume  = 1'b0;
        end
      end
      M_STRING, M_ESCAPE: begin
        if (s_end) begin
          emit        = 1'b1;
          erec.kind   = KIND_STRING;
          erec.column = tsc_r;
          erec.length = tlen_r;
          mode_nxt    = M_IDLE;
          consume     = 1'b0;
        end else begin
          if (tlen_r != {LENGTH_BITS{1'b1}}) tlen_nxt = tlen_r + 1'b1;
          if (mode_r == M_ESCAPE) begin
            col_nxt  = col_plus(col_r, 5'd1);
            mode_nxt = M_STRING;
          end else if (c == CH_BSLASH) begin
            mode_nxt = M_ESCAPE;
            col_nxt  = col_plus(col_r, 5'd1);
          end else if (c == (qs_r ? CH_SQUOTE : CH_DQUOTE)) begin
            col_nxt     = col_plus(col_r, 5'd1);
            emit        = 1'b1;
            erec.kind   = KIND_STRING;
            erec.column = tsc_r;
            erec.length = tlen_nxt;
            mode_nxt    = M_IDLE;
          end else if (c == CH_NL) begin
            if (line_r != {LINE_BITS{1'b1}}) line_nxt = line_r + 1'b1;
            col_nxt = COLUMN_BITS'(1);
          end else begin
            col_nxt = col_plus(col_r, 5'd1);
          end
        end
      end
      M_NUMBER: begin
        if (!s_end && (cur.digit || c == CH_DOT)) begin
          if (tlen_r != {LENGTH_BITS{1'b1}}) tlen_nxt = tlen_r + 1'b1;
          col_nxt = col_plus(col_r, 5'd1);
        end else begin
          emit        = 1'b1;
          erec.kind   = KIND_NUMBER;
          erec.column = tsc_r;
          erec.length = tlen_r;
          mode_nxt    = M_IDLE;
          consume     = 1'b0;
        end
      end
      M_OPER: begin
        emit        = 1'b1;
        erec.column = tsc_r;
        erec.code   = pop_r;
        mode_nxt    = M_IDLE;
        if (!s_end && (pop_r == CH_EQ || pop_r == CH_BAR) && c == CH_GT) begin
          erec.kind   = (pop_r == CH_EQ) ? KIND_ARROW : KIND_PIPE;
          erec.length = LENGTH_BITS'(2);
          col_nxt     = col_plus(col_r, 5'd2);
        end else if (!s_end && pop_r != CH_BAR && c == CH_EQ) begin
          erec.kind   = KIND_COMPARE;
          erec.length = LENGTH_BITS'(2);
          col_nxt     = col_plus(col_r, 5'd2);
        end else begin
          erec.kind   = (pop_r == CH_EQ) ? KIND_ASSIGN :
                        ((pop_r == CH_GT || pop_r == CH_LT) ? KIND_COMPARE : KIND_OPER);
          erec.length = LENGTH_BITS'(1);
          col_nxt     = col_plus(col_r, 5'd1);
          consume     = 1'b0;
        end
      end
      M_WORD, M_WORD_PLAIN: begin
        if (!s_end && cur.ident) begin
          wp_we = (tlen_r < LENGTH_BITS'(PREFIX_DEPTH));
          if (tlen_r != {LENGTH_BITS{1'b1}}) tlen_nxt = tlen_r + 1'b1;
          col_nxt = col_plus(col_r, 5'd1);
        end else if (mode_r == M_WORD && !s_end && c == CH_DOT &&
                     tlen_r == LENGTH_BITS'(6) &&
                     {wp_r[0], wp_r[1], wp_r[2], wp_r[3], wp_r[4], wp_r[5]} == "takdir") begin
          mode_nxt  = M_TAKDIR;
          la_we     = 1'b1;
          la_idx    = '0;
          lacnt_nxt = LA_CNT_BITS'(1);
        end else if (!s_end && c == CH_SPACE && tlen_r == LENGTH_BITS'(5) &&
                     ({wp_r[0], wp_r[1], wp_r[2], wp_r[3], wp_r[4]} == "butuh" ||
                      {wp_r[0], wp_r[1], wp_r[2], wp_r[3], wp_r[4]} == "untuk")) begin
          mode_nxt  = M_PRAGMA;
          la_we     = 1'b1;
          la_idx    = '0;
          lacnt_nxt = LA_CNT_BITS'(1);
          alive_nxt = (wp_r[0] == CH_LOW_B) ? 3'b001 : 3'b110;
        end else begin
          emit        = 1'b1;
          erec.kind   = kw.hit ? kw.kind : KIND_IDENT;
          erec.code   = kw.hit ? CODE_BITS'(kw.code) : '0;
          erec.column = tsc_r;
          erec.length = tlen_r;
          mode_nxt    = M_IDLE;
          consume     = 1'b0;
        end
      end
      M_TAKDIR: begin
        if (lacnt_r >= LA_CNT_BITS'(5)) begin
          if (s_end || !cur.ident) begin
            emit        = 1'b1;
            erec.kind   = KIND_TAKDIR;
            erec.column = tsc_r;
            erec.length = LENGTH_BITS'(11);
            erec.code   = (la_r[1] == CH_LOW_S) ? '0 : CODE_BITS'(1);
            col_nxt     = col_plus(tsc_r, 5'd11);
            lacnt_nxt   = '0;
            mode_nxt    = M_IDLE;
            consume     = 1'b0;
          end else begin
            fail = 1'b1;
          end
        end else if (!s_end && lacnt_r == LA_CNT_BITS'(1) &&
                     (c == CH_LOW_S || c == CH_LOW_H)) begin
          la_we     = 1'b1;
          lacnt_nxt = lacnt_r + 1'b1;
        end else if (!s_end && lacnt_r > LA_CNT_BITS'(1) &&
                     c == takdir_byte(la_r[1] != CH_LOW_S, lacnt_r)) begin
          la_we     = 1'b1;
          lacnt_nxt = lacnt_r + 1'b1;
        end else begin
          fail = 1'b1;
        end
        if (fail) begin
          mode_nxt  = M_WORD_PLAIN;
          rep_go    = 1'b1;
          consume   = 1'b0;
          lacnt_nxt = '0;
        end
      end
      M_PRAGMA: begin
        if (!s_end && lacnt_r < LA_CNT_BITS'(LOOKAHEAD_DEPTH)) begin
          for (int k = 2; k >= 0; k--) begin
            if (alive_r[k] && lacnt_r < LA_CNT_BITS'(PHRASE_LEN[k]) &&
                phrase_byte(2'(k), lacnt_r) == c) begin
              if (lacnt_r + 1'b1 == LA_CNT_BITS'(PHRASE_LEN[k])) begin
                done   = 1'b1;
                done_k = 2'(k);
              end else begin
                new_alive[k] = 1'b1;
              end
            end
          end
        end
        if (done) begin
          emit        = 1'b1;
          erec.kind   = KIND_PRAGMA;
          erec.column = tsc_r;
          erec.length = LENGTH_BITS'(5) + LENGTH_BITS'(PHRASE_LEN[done_k]);
          erec.code   = CODE_BITS'(done_k);
          col_nxt     = col_plus(col_r, 5'(PHRASE_LEN[done_k]));
          lacnt_nxt   = '0;
          mode_nxt    = M_IDLE;
        end else if (new_alive != '0) begin
          la_we     = 1'b1;
          lacnt_nxt = lacnt_r + 1'b1;
          alive_nxt = new_alive;
        end else begin
          emit        = 1'b1;
          erec.kind   = kw.hit ? kw.kind : KIND_IDENT;
          erec.code   = kw.hit ? CODE_BITS'(kw.code) : '0;
          erec.column = tsc_r;
          erec.length = tlen_r;
          mode_nxt    = M_IDLE;
          rep_go      = 1'b1;
          consume     = 1'b0;
          lacnt_nxt   = '0;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
        consume  = 1'b0;
      end
    endcase
  end

  // Symbol sequencing, replay pointers and the record hold and output stages.
  always_comb begin
    have_nxt      = have_r;
    sym_nxt       = sym_r;
    rep_cnt_nxt   = rep_cnt_r;
    rep_idx_nxt   = rep_idx_r;
    hold_v_nxt    = hold_v_r;
    hold_last_nxt = hold_last_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    if (sym_pop) begin
      have_nxt    = 1'b1;
      sym_nxt     = sym_in;
      rep_cnt_nxt = '0;
      rep_idx_nxt = '0;
    end
    if (step) begin
      if (rep_go) begin
        rep_idx_nxt = '0;
        rep_cnt_nxt = lacnt_r;
      end else if (consume && replaying) begin
        rep_idx_nxt = rep_idx_r + 1'b1;
      end
      if (finish) begin
        have_nxt = 1'b0;
      end
    end
    if (hold_last_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_rec_nxt   = hold_r;
      out_last_nxt  = 1'b1;
      hold_v_nxt    = 1'b0;
      hold_last_nxt = 1'b0;
    end else if (step && emit) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_rec_nxt   = hold_r;
        out_last_nxt  = 1'b0;
      end
      hold_nxt      = erec;
      hold_v_nxt    = 1'b1;
      hold_last_nxt = finish;
    end else if (finish && hold_v_r) begin
      hold_last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      have_r      <= 1'b0;
      rep_cnt_r   <= '0;
      rep_idx_r   <= '0;
      line_r      <= LINE_BITS'(1);
      col_r       <= COLUMN_BITS'(1);
      tsc_r       <= '0;
      tlen_r      <= '0;
      qs_r        <= 1'b0;
      pop_r       <= '0;
      lacnt_r     <= '0;
      alive_r     <= '0;
      hold_v_r    <= 1'b0;
      hold_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      have_r      <= have_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      rep_idx_r   <= rep_idx_nxt;
      hold_v_r    <= hold_v_nxt;
      hold_last_r <= hold_last_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        mode_r  <= mode_nxt;
        line_r  <= line_nxt;
        col_r   <= col_nxt;
        tsc_r   <= tsc_nxt;
        tlen_r  <= tlen_nxt;
        qs_r    <= qs_nxt;
        pop_r   <= pop_nxt;
        lacnt_r <= lacnt_nxt;
        alive_r <= alive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    hold_r     <= hold_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
    if (step && wp_we) begin
      wp_r[wp_idx] <= wr_byte;
    end
    if (step && la_we) begin
      la_r[la_idx] <= wr_byte;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_rec_r.kind;
  assign out_line      = out_rec_r.line;
  assign out_column    = out_rec_r.column;
  assign out_length    = out_rec_r.length;
  assign out_word_code = out_rec_r.code;
  assign out_last      = out_last_r;

  `STSC_ASSERT(a_hold_last_has_rec, !hold_last_r || hold_v_r)
  `STSC_ASSERT(a_replay_in_range, rep_idx_r <= rep_cnt_r)
  `STSC_ASSERT(a_no_record_overrun, !(step && emit && hold_v_r) || out_free)
  `STSC_ASSERT_NEXT(a_finish_flushes, finish && (emit || hold_v_r), hold_last_r)

endmodule

// ----- tb/sv/source_token_scanner_checker.sv -----
// ----------------------------------------------------------------------------
// source_token_scanner_checker
// Watches both channels of the scanner and predicts every token record from
// the accepted source bytes. It compares each record field by field and
// reports mismatches and the number of records still outstanding.
// ----------------------------------------------------------------------------
module source_token_scanner_checker import stsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_ch,
  input  logic                   in_at_end,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [KIND_BITS-1:0]   out_kind,
  input  logic [LINE_BITS-1:0]   out_line,
  input  logic [COLUMN_BITS-1:0] out_column,
  input  logic [LENGTH_BITS-1:0] out_length,
  input  logic [CODE_BITS-1:0]   out_word_code,
  input  logic                   out_last,
  output int                     errors,
  output int                     pending
);

  localparam int END_SYM   = 256;
  localparam int MAX_RECS  = 8;
  localparam int STACK_CAP = 2 * LOOKAHEAD_DEPTH + 4;
  localparam int LINE_TOP  = (1 << LINE_BITS) - 1;
  localparam int COL_TOP   = (1 << COLUMN_BITS) - 1;
  localparam int LEN_TOP   = (1 << LENGTH_BITS) - 1;

  typedef enum int {
    LX_IDLE, LX_CARET, LX_COMMENT, LX_STRING, LX_ESCAPE, LX_NUMBER, LX_OPER,
    LX_WORD, LX_WORD_PLAIN, LX_TAKDIR, LX_PRAGMA
  } lex_mode_e;

  typedef struct {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [LENGTH_BITS-1:0] length;
    logic [CODE_BITS-1:0]   code;
    logic                   last;
  } token_rec_t;

  string kw_txt [29] = '{
    "datang", "cocokkan", "kasus", "jika", "kecuali", "maka", "lain", "putus",
    "effort", "kali", "dan", "atau", "bukan", "coba", "tabu", "melanggar",
    "tebus", "pasrah", "ciptakan", "fungsi", "pulang", "sowan", "utas", "gaib",
    "pergi", "henti", "balikan", "terus", "jadwal"
  };
  int kw_kind [29] = '{18, 19, 20, 21, 21, 21, 21, 21, 22, 22, 23, 23, 23, 24,
                       25, 26, 27, 28, 29, 30, 31, 32, 33, 33, 34, 34, 34, 34, 35};
  int kw_code [29] = '{0, 0, 0, 0, 1, 2, 3, 4, 0, 1, 0, 1, 2, 0,
                       0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 2, 3, 0};
  string phrase [3] = '{" .anu", " array.dinamis", " array.statis"};
  string punct = "(){}[],:.";

  int         ln, col, tok_col, tok_len, la_n;
  lex_mode_e  mode;
  bit         q_single;
  logic [7:0] pend_op;
  logic [7:0] pfx [PREFIX_DEPTH];
  logic [7:0] la [LOOKAHEAD_DEPTH];
  int         sym_stack [$];
  token_rec_t step_recs [$];
  token_rec_t token_q [$];
  int         shown;

  function automatic void clear_scanner();
    ln = 1; col = 1; mode = LX_IDLE; tok_col = 0; tok_len = 0;
    q_single = 0; pend_op = '0; la_n = 0;
  endfunction

  function automatic bit is_dig(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alp(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_idc(int c);
    return is_alp(c) || is_dig(c) || c == CH_UNDER;
  endfunction

  function automatic void col_add(int n);
    col = (col + n > COL_TOP) ? COL_TOP : col + n;
  endfunction

  function automatic void next_line();
    if (ln < LINE_TOP) ln++;
    col = 1;
  endfunction

  function automatic void len_inc();
    if (tok_len < LEN_TOP) tok_len++;
  endfunction

  function automatic void push_sym(int s);
    if (sym_stack.size() < STACK_CAP) sym_stack.push_back(s);
  endfunction

  function automatic void put(int kind, int c, int len, int code);
    token_rec_t r;
    if (step_recs.size() < MAX_RECS) begin
      r.kind   = KIND_BITS'(kind);
      r.line   = LINE_BITS'(ln);
      r.column = COLUMN_BITS'(c);
      r.length = LENGTH_BITS'(len > LEN_TOP ? LEN_TOP : len);
      r.code   = CODE_BITS'(code);
      r.last   = 1'b0;
      step_recs.push_back(r);
    end
  endfunction

  function automatic bit prefix_is(string w, int n);
    for (int i = 0; i < n; i++)
      if (pfx[i] != w[i]) return 0;
    return 1;
  endfunction

  function automatic void put_word();
    if (tok_len <= PREFIX_DEPTH) begin
      for (int k = 0; k < 29; k++) begin
        if (kw_txt[k].len() == tok_len && prefix_is(kw_txt[k], tok_len)) begin
          put(kw_kind[k], tok_col, tok_len, kw_code[k]);
          return;
        end
      end
    end
    put(KIND_IDENT, tok_col, tok_len, 0);
  endfunction

  // Buffered phrase bytes go back on the stack so they are lexed again.
  function automatic void rescan(int cur);
    int i;
    i = la_n > LOOKAHEAD_DEPTH ? LOOKAHEAD_DEPTH : la_n;
    push_sym(cur);
    while (i > 0) begin
      i--;
      push_sym(la[i]);
    end
    la_n = 0;
  endfunction

  function automatic void idle_sym(int s);
    int c;
    c = s & 255;
    if (s == END_SYM) begin
      put(KIND_EOF, col, 0, 0);
      clear_scanner();
      return;
    end
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin col_add(1); return; end
    if (c == CH_NL) begin next_line(); return; end
    if (c == CH_CARET) begin mode = LX_CARET; tok_col = col; return; end
    for (int k = 0; k < 9; k++) begin
      if (punct[k] == c) begin
        put(k, col, 1, c);
        col_add(1);
        return;
      end
    end
    tok_col = col;
    if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      mode = LX_STRING; q_single = (c == CH_SQUOTE); tok_len = 1; col_add(1);
    end else if (is_dig(c)) begin
      mode = LX_NUMBER; tok_len = 1; col_add(1);
    end else if (c == CH_EQ || c == CH_BANG || c == CH_GT || c == CH_LT || c == CH_BAR) begin
      mode = LX_OPER; pend_op = c;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                 c == CH_PERCENT) begin
      put(KIND_OPER, col, 1, c); col_add(1);
    end else if (is_alp(c) || c == CH_UNDER) begin
      mode = LX_WORD; pfx[0] = c; tok_len = 1; col_add(1);
    end else begin
      put(KIND_MISMATCH, col, 1, c); col_add(1);
    end
  endfunction

  function automatic void word_sym(int s);
    int c;
    bit e;
    c = s & 255;
    e = (s == END_SYM);
    if (!e && is_idc(c)) begin
      if (tok_len < PREFIX_DEPTH) pfx[tok_len] = c;
      len_inc(); col_add(1);
      return;
    end
    if (mode == LX_WORD && !e && c == CH_DOT && tok_len == 6 && prefix_is("takdir", 6)) begin
      mode = LX_TAKDIR; la[0] = CH_DOT; la_n = 1;
      return;
    end
    if (!e && c == CH_SPACE && tok_len == 5 && (prefix_is("butuh", 5) || prefix_is("untuk", 5)))
    begin
      mode = LX_PRAGMA; la[0] = CH_SPACE; la_n = 1;
      return;
    end
    put_word();
    mode = LX_IDLE;
    push_sym(s);
  endfunction

  function automatic void takdir_sym(int s);
    int    c, n;
    bit    e, ok;
    string tail;
    c = s & 255; n = la_n; e = (s == END_SYM); ok = 0;
    if (n >= 5) begin
      if (e || !is_idc(c)) begin
        put(KIND_TAKDIR, tok_col, 11, la[1] == CH_LOW_S ? 0 : 1);
        col = (tok_col + 11 > COL_TOP) ? COL_TOP : tok_col + 11;
        la_n = 0; mode = LX_IDLE;
        push_sym(s);
        return;
      end
    end else if (!e && n >= 1) begin
      if (n == 1) ok = (c == CH_LOW_S || c == CH_LOW_H);
      else begin
        tail = (la[1] == CH_LOW_S) ? "soft" : "hard";
        ok = (c == tail[n-1]);
      end
      if (ok) begin la[n] = c; la_n = n + 1; return; end
    end
    mode = LX_WORD_PLAIN;
    rescan(s);
  endfunction

  function automatic void pragma_sym(int s);
    int c, n, first, lastk;
    bit alive, same;
    c = s & 255; n = la_n; alive = 0;
    if (s != END_SYM && n < LOOKAHEAD_DEPTH) begin
      first = (pfx[0] == CH_LOW_B) ? 0 : 1;
      lastk = (pfx[0] == CH_LOW_B) ? 0 : 2;
      for (int k = first; k <= lastk; k++) begin
        same = (n < phrase[k].len());
        for (int i = 0; i < n && same; i++) same = (la[i] == phrase[k][i]);
        if (same && phrase[k][n] == c) begin
          if (n + 1 == phrase[k].len()) begin
            put(KIND_PRAGMA, tok_col, 5 + phrase[k].len(), k);
            col_add(phrase[k].len());
            la_n = 0; mode = LX_IDLE;
            return;
          end
          alive = 1;
        end
      end
      if (alive) begin la[n] = c; la_n = n + 1; return; end
    end
    put_word();
    mode = LX_IDLE;
    rescan(s);
  endfunction

  function automatic void scan_symbol(int s);
    int c, kind, two;
    bit e;
    c = s & 255;
    e = (s == END_SYM);
    case (mode)
      LX_IDLE: idle_sym(s);
      LX_CARET: begin
        if (!e && c == CH_CARET) mode = LX_COMMENT;
        else begin
          put(KIND_OPER, tok_col, 1, CH_CARET); col_add(1);
          mode = LX_IDLE; push_sym(s);
        end
      end
      LX_COMMENT: if (e || c == CH_NL) begin mode = LX_IDLE; push_sym(s); end
      LX_STRING, LX_ESCAPE: begin
        if (e) begin
          // The end mark closes an open string, even right after a backslash.
          put(KIND_STRING, tok_col, tok_len, 0);
          mode = LX_IDLE; push_sym(s);
        end else if (mode == LX_ESCAPE) begin
          len_inc(); col_add(1); mode = LX_STRING;
        end else begin
          len_inc();
          if (c == CH_BSLASH) begin
            mode = LX_ESCAPE; col_add(1);
          end else if (c == (q_single ? CH_SQUOTE : CH_DQUOTE)) begin
            col_add(1); put(KIND_STRING, tok_col, tok_len, 0); mode = LX_IDLE;
          end else if (c == CH_NL) next_line();
          else col_add(1);
        end
      end
      LX_NUMBER: begin
        if (!e && (is_dig(c) || c == CH_DOT)) begin len_inc(); col_add(1); end
        else begin
          put(KIND_NUMBER, tok_col, tok_len, 0);
          mode = LX_IDLE; push_sym(s);
        end
      end
      LX_OPER: begin
        two = 0;
        if (!e) begin
          if (pend_op == CH_EQ && c == CH_GT) two = KIND_ARROW;
          else if (pend_op == CH_BAR && c == CH_GT) two = KIND_PIPE;
          else if ((pend_op == CH_EQ || pend_op == CH_BANG || pend_op == CH_GT ||
                    pend_op == CH_LT) && c == CH_EQ) two = KIND_COMPARE;
        end
        if (two != 0) begin
          put(two, tok_col, 2, pend_op); col_add(2); mode = LX_IDLE;
        end else begin
          kind = (pend_op == CH_EQ) ? KIND_ASSIGN :
                 ((pend_op == CH_GT || pend_op == CH_LT) ? KIND_COMPARE : KIND_OPER);
          put(kind, tok_col, 1, pend_op); col_add(1);
          mode = LX_IDLE; push_sym(s);
        end
      end
      LX_WORD, LX_WORD_PLAIN: word_sym(s);
      LX_TAKDIR: takdir_sym(s);
      LX_PRAGMA: pragma_sym(s);
      default: begin mode = LX_IDLE; push_sym(s); end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] ch, logic at_end);
    int guard;
    guard = 0;
    step_recs.delete();
    sym_stack.delete();
    push_sym(at_end ? END_SYM : int'(ch));
    while (sym_stack.size() > 0 && guard < 1024) begin
      scan_symbol(sym_stack.pop_back());
      guard++;
    end
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1'b1;
    foreach (step_recs[i]) token_q.push_back(step_recs[i]);
  endfunction

  function automatic void check_token();
    token_rec_t x;
    if (token_q.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("checker: unexpected record kind %0d line %0d col %0d", out_kind, out_line,
                 out_column);
      end
      return;
    end
    x = token_q.pop_front();
    if (out_kind !== x.kind || out_line !== x.line || out_column !== x.column ||
        out_length !== x.length || out_word_code !== x.code || out_last !== x.last) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("checker: mismatch exp kind %0d line %0d col %0d len %0d code %0d last %0d",
                 x.kind, x.line, x.column, x.length, x.code, x.last);
        $display("checker:          got kind %0d line %0d col %0d len %0d code %0d last %0d",
                 out_kind, out_line, out_column, out_length, out_word_code, out_last);
      end
    end
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    shown = 0;
    clear_scanner();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scanner();
      token_q.delete();
    end else begin
      if (out_valid && out_ready) check_token();
      if (in_valid && in_ready) predict_tokens(in_ch, in_at_end);
    end
    pending = token_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives source text into the token scanner in random bursts, with a stalling
// receiver, and reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import stsc_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_ch;
  logic                   in_at_end;
  logic                   out_valid;
  logic                   out_ready;
  logic [KIND_BITS-1:0]   out_kind;
  logic [LINE_BITS-1:0]   out_line;
  logic [COLUMN_BITS-1:0] out_column;
  logic [LENGTH_BITS-1:0] out_length;
  logic [CODE_BITS-1:0]   out_word_code;
  logic                   out_last;
  int                     errors;
  int                     pending;
  int                     bytes_sent;
  int                     burst_left;
  bit                     hold_done;

  string kw_list [29] = '{
    "datang", "cocokkan", "kasus", "jika", "kecuali", "maka", "lain", "putus",
    "effort", "kali", "dan", "atau", "bukan", "coba", "tabu", "melanggar",
    "tebus", "pasrah", "ciptakan", "fungsi", "pulang", "sowan", "utas", "gaib",
    "pergi", "henti", "balikan", "terus", "jadwal"
  };
  string pragma_list [3] = '{"butuh .anu", "untuk array.dinamis", "untuk array.statis"};
  string oper_list [17] = '{"=>", "|>", "==", "!=", "<=", ">=", "<", ">", "=", "!", "|",
                            "+", "-", "*", "/", "%", "^"};
  string punct = "(){}[],:.";
  string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  source_token_scanner_unit uut (.*);

  source_token_scanner_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic send_sym(input logic [7:0] b, input logic e);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_ch     <= b;
    in_at_end <= e;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_sym(s[i], 1'b0);
  endtask

  // The end mark carries a random byte so the ignored field still toggles.
  task automatic send_end();
    send_sym($urandom_range(0, 255), 1'b1);
  endtask

  function automatic string rand_ident(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i == 0) s = {s, string'(ident_chars[$urandom_range(0, 52)])};
      else s = {s, string'(ident_chars[$urandom_range(0, 62)])};
    end
    return s;
  endfunction

  function automatic string rand_fragment();
    string s, t;
    int    n;
    s = "";
    case ($urandom_range(0, 16))
      0, 1: s = {kw_list[$urandom_range(0, 28)], " "};
      2: begin
        s = $urandom_range(0, 1) ? "takdir.soft" : "takdir.hard";
        case ($urandom_range(0, 3))
          0: s = {s, " "};
          1: s = {s, "("};
          2: s = {s, "x"};
          default: s = {s, "\n"};
        endcase
      end
      3: begin
        t = $urandom_range(0, 1) ? "soft" : "hard";
        s = {"takdir.", t.substr(0, $urandom_range(0, 3) - 1), string'(punct[$urandom_range(0, 8)])};
      end
      4, 5: s = pragma_list[$urandom_range(0, 2)];
      6: begin
        t = pragma_list[$urandom_range(0, 2)];
        s = {t.substr(0, $urandom_range(4, t.len() - 2)), rand_ident($urandom_range(1, 3))};
      end
      7: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) s = {s, $urandom_range(0, 3) ? "7" : "."};
        s = {s, " "};
      end
      8: begin
        t = $urandom_range(0, 1) ? "'" : "\"";
        s = t;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: s = {s, "\\", $urandom_range(0, 1) ? "\n" : t};
            1: s = {s, "\n"};
            2: s = {s, $urandom_range(0, 1) ? "'" : "\""};
            default: s = {s, rand_ident(1)};
          endcase
        end
        if ($urandom_range(0, 5) != 0) s = {s, t};
      end
      9: s = {"^^", rand_ident($urandom_range(0, 5)), " ^", "\n"};
      10: s = oper_list[$urandom_range(0, 16)];
      11: s = string'(punct[$urandom_range(0, 8)]);
      12: s = {rand_ident($urandom_range(1, 16)), " "};
      13: s = $urandom_range(0, 1) ? " " : ($urandom_range(0, 1) ? "\t" : "\r");
      14: s = "\n";
      default: s = string'(8'($urandom_range(0, 255)));
    endcase
    return s;
  endfunction

  // The receiver stalls on a changing pattern, with one long hold-off once the
  // sender is well under way so that the block backs up into its input.
  initial begin
    int rx_mode, rx_left, hold_left;
    rx_mode = 0; rx_left = 0; hold_left = 0;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && bytes_sent >= 150) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        if (rx_left <= 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int    random_bytes, waited;
    string s;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_ch      = '0;
    in_at_end  = 1'b0;
    bytes_sent = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: takdir, a pragma, punctuation, and an escape cut off by the end.
    send_text("takdir.hard(butuh .anu\"a\\");
    send_end();
    send_text("x=>1.2\n");
    send_end();

    random_bytes = 0;
    while (random_bytes < 385) begin
      s = rand_fragment();
      send_text(s);
      random_bytes += s.len();
      if ($urandom_range(0, 30) == 0) begin
        send_end();
        random_bytes++;
      end
    end
    send_end();

    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
